/* sv/fsp_pkg.sv */
// Shared types, constants and tables of the footstep target planner.
// No dependencies; used by fsp_cordic and footstep_target_planner_core.
`default_nettype none
package fsp_pkg;

  localparam int VEL_DEADBAND = 164;
  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam int FRAC_BITS = 12;
  localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032875;

  localparam logic signed [15:0] FWD_MAX = 16'sd12288;
  localparam logic signed [15:0] FWD_MIN = -16'sd16384;
  localparam logic signed [15:0] SIDE_MAX = 16'sd16384;
  localparam logic signed [15:0] SIDE_MIN = -16'sd16384;
  localparam logic signed [15:0] TURN_MAX = 16'sd13107;
  localparam logic signed [15:0] TURN_MIN = -16'sd13107;

  localparam logic [1:0] LEG_LEFT = 2'd0;
  localparam logic [1:0] LEG_RIGHT = 2'd1;
  localparam logic [1:0] LEG_BOTH = 2'd2;

  typedef enum logic [2:0] {
    REG_HIP_HALF = 3'd0,
    REG_HIP_BACK = 3'd1,
    REG_FWD_MAX = 3'd2,
    REG_BWD_MAX = 3'd3,
    REG_SIDE_MAX = 3'd4,
    REG_TURN_OUT = 3'd5,
    REG_TURN_IN = 3'd6,
    REG_PHASES = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SX, ST_SY, ST_TURN, ST_ROT1, ST_ROT1_WAIT, ST_G1X, ST_G1Y,
    ST_ROT2, ST_ROT2_WAIT, ST_G2X, ST_G2Y, ST_FLUSH, ST_SUM
  } state_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_SX, DST_SY, DST_TURN, DST_PX, DST_PY, DST_QX, DST_QY
  } dst_t;

  function automatic logic signed [31:0] atan_angle(input logic [4:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0: a = 32'sd536870912;
      5'd1: a = 32'sd316933406;
      5'd2: a = 32'sd167458907;
      5'd3: a = 32'sd85004756;
      5'd4: a = 32'sd42667331;
      5'd5: a = 32'sd21354465;
      5'd6: a = 32'sd10679838;
      5'd7: a = 32'sd5340245;
      5'd8: a = 32'sd2670163;
      5'd9: a = 32'sd1335087;
      5'd10: a = 32'sd667544;
      5'd11: a = 32'sd333772;
      5'd12: a = 32'sd166886;
      5'd13: a = 32'sd83443;
      5'd14: a = 32'sd41722;
      5'd15: a = 32'sd20861;
      5'd16: a = 32'sd10430;
      5'd17: a = 32'sd5215;
      5'd18: a = 32'sd2608;
      5'd19: a = 32'sd1304;
      5'd20: a = 32'sd652;
      5'd21: a = 32'sd326;
      5'd22: a = 32'sd163;
      5'd23: a = 32'sd81;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

/* sv/fsp_cordic.sv */
// Iterative CORDIC rotator: one micro-rotation per cycle, counter-clockwise.
// Depends on fsp_pkg for the step count and the arctangent table.
`default_nettype none
module fsp_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [17:0] x0,
  input  wire logic signed [17:0] y0,
  input  wire logic [15:0]        angle,
  output logic                    busy,
  output logic signed [31:0]      x,
  output logic signed [31:0]      y
);

  logic [fsp_pkg::CNT_W-1:0] cnt;
  logic signed [31:0] z;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic flip;

  assign flip = angle[15] ^ angle[14];
  assign xs = 32'(x0) <<< fsp_pkg::FRAC_BITS;
  assign ys = 32'(y0) <<< fsp_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == fsp_pkg::CNT_W'(fsp_pkg::CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= flip ? -xs : xs;
      y <= flip ? -ys : ys;
      z <= {angle[15] ^ flip, angle[14:0], 16'b0};
    end else if (busy) begin
      if (!z[31]) begin
        x <= x - (y >>> cnt);
        y <= y + (x >>> cnt);
        z <= z - fsp_pkg::atan_angle(5'(cnt));
      end else begin
        x <= x + (y >>> cnt);
        y <= y - (x >>> cnt);
        z <= z + fsp_pkg::atan_angle(5'(cnt));
      end
    end
  end

endmodule
`default_nettype wire

/* sv/footstep_target_planner_core.sv */
// Footstep target planner: sequencer, shared multiplier, registers, output stage.
// Depends on fsp_pkg and fsp_cordic.
//
// Usage: an input item on s_tvalid/s_tready/s_tdata carries the velocity
// command, the support leg and the support foot pose. One result item per
// input leaves on m_tvalid/m_tready/m_tdata with the next footstep target.
// s_tready is high only while the sequencer is idle. An item is processed by
// two CORDIC rotations on the one rotator, with one shared 32x31 multiplier
// doing the step scaling and gain correction. A new item is accepted only
// after the previous result has been loaded into the output register.
// The result sits in an output register; a new item is accepted while it
// waits, and a stalled receiver holds the sequencer only at its last step.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are to be made by the user while idle; the block does not enforce it. Reset
// restores the register defaults and marks the previous command as zero.
`default_nettype none
module footstep_target_planner_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // vel_forward[15:0] vel_side[31:16] vel_turn[47:32] support_leg[49:48]
  // foot_x[71:50] foot_y[93:72] foot_heading[109:94] step_index[125:110]
  input  wire logic [127:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // target_x[21:0] target_y[43:22] target_heading[59:44] next_support[61:60]
  // zmp_leg[63:62] phases[71:64] next_step_index[87:72]
  output logic [87:0]       m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [14:0]  cfg_data
);

  logic [14:0] hip_half_offset;
  logic [13:0] forward_step_max, backward_step_max, side_step_max;
  logic [13:0] turn_out_max, turn_in_max;
  logic [7:0]  phase_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      hip_half_offset <= 15'd3277;
      forward_step_max <= 14'd2621;
      backward_step_max <= 14'd1966;
      side_step_max <= 14'd1310;
      turn_out_max <= 14'd3641;
      turn_in_max <= 14'd3641;
      phase_count <= 8'd30;
    end else if (cfg_we) begin
      unique case (fsp_pkg::reg_index_t'(cfg_index))
        fsp_pkg::REG_HIP_HALF: hip_half_offset <= cfg_data;
        fsp_pkg::REG_HIP_BACK: ;
        fsp_pkg::REG_FWD_MAX: forward_step_max <= cfg_data[13:0];
        fsp_pkg::REG_BWD_MAX: backward_step_max <= cfg_data[13:0];
        fsp_pkg::REG_SIDE_MAX: side_step_max <= cfg_data[13:0];
        fsp_pkg::REG_TURN_OUT: turn_out_max <= cfg_data[13:0];
        fsp_pkg::REG_TURN_IN: turn_in_max <= cfg_data[13:0];
        fsp_pkg::REG_PHASES: phase_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] in_vf, in_vs, in_vt, db_vf, db_vs, db_vt, cl_vf, cl_vs, cl_vt;
  logic signed [15:0] band;
  logic dead, in_zero;

  assign in_vf = s_tdata[15:0];
  assign in_vs = s_tdata[31:16];
  assign in_vt = s_tdata[47:32];
  assign band = 16'(fsp_pkg::VEL_DEADBAND);

  always_comb begin
    dead = (in_vf > -band) && (in_vf < band) &&
           (in_vs > -band) && (in_vs < band) &&
           (in_vt > -band) && (in_vt < band);
    db_vf = dead ? 16'sd0 : in_vf;
    db_vs = dead ? 16'sd0 : in_vs;
    db_vt = dead ? 16'sd0 : in_vt;
    cl_vf = db_vf < fsp_pkg::FWD_MIN ? fsp_pkg::FWD_MIN :
            (db_vf > fsp_pkg::FWD_MAX ? fsp_pkg::FWD_MAX : db_vf);
    cl_vs = db_vs < fsp_pkg::SIDE_MIN ? fsp_pkg::SIDE_MIN :
            (db_vs > fsp_pkg::SIDE_MAX ? fsp_pkg::SIDE_MAX : db_vs);
    cl_vt = db_vt < fsp_pkg::TURN_MIN ? fsp_pkg::TURN_MIN :
            (db_vt > fsp_pkg::TURN_MAX ? fsp_pkg::TURN_MAX : db_vt);
    in_zero = (cl_vf == 16'sd0) && (cl_vs == 16'sd0) && (cl_vt == 16'sd0);
  end

  logic signed [15:0] vf, vs, vt;
  logic [1:0] leg;
  logic signed [21:0] fx, fy;
  logic [15:0] head, step_index;
  logic stand, prev_command_zero;
  logic accept;

  fsp_pkg::state_t state, state_next;
  assign s_tready = (state == fsp_pkg::ST_IDLE);
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_command_zero <= 1'b1;
    end else if (accept) begin
      prev_command_zero <= in_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vf <= cl_vf;
      vs <= cl_vs;
      vt <= cl_vt;
      leg <= s_tdata[49:48];
      fx <= s_tdata[71:50];
      fy <= s_tdata[93:72];
      head <= s_tdata[109:94];
      step_index <= s_tdata[125:110];
      stand <= in_zero && prev_command_zero;
    end
  end

  logic right, left;
  logic signed [15:0] hip;
  assign right = (leg == fsp_pkg::LEG_RIGHT);
  assign left = (leg == fsp_pkg::LEG_LEFT);
  assign hip = left ? -16'(hip_half_offset) : 16'(hip_half_offset);

  logic signed [17:0] sx, sy, turn, px, py, qx, qy;
  logic [15:0] head2;
  assign head2 = head + turn[15:0];

  logic cstart, cbusy;
  logic signed [17:0] cx0, cy0;
  logic [15:0] cang;
  logic signed [31:0] cx, cy;

  fsp_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .x0(cx0), .y0(cy0), .angle(cang),
    .busy(cbusy), .x(cx), .y(cy)
  );

  logic signed [31:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [62:0] prod;
  fsp_pkg::dst_t dst, pdst;
  logic out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsp_pkg::ST_IDLE;
      pdst <= fsp_pkg::DST_NONE;
    end else begin
      state <= state_next;
      pdst <= dst;
    end
  end

  always_comb begin
    state_next = state;
    dst = fsp_pkg::DST_NONE;
    mul_a = 32'(vf);
    mul_b = fsp_pkg::INV_GAIN_Q30;
    cstart = 1'b0;
    cx0 = sx;
    cy0 = sy + 18'(hip);
    cang = head;
    out_load = 1'b0;
    unique case (state)
      fsp_pkg::ST_IDLE: if (accept) state_next = fsp_pkg::ST_SX;
      fsp_pkg::ST_SX: begin
        mul_a = 32'(vf);
        mul_b = 31'(vf > 16'sd0 ? forward_step_max : backward_step_max);
        dst = fsp_pkg::DST_SX;
        state_next = fsp_pkg::ST_SY;
      end
      fsp_pkg::ST_SY: begin
        mul_a = 32'(vs);
        mul_b = ((right && vs > 16'sd0) || (!right && vs <= 16'sd0)) ?
                31'(side_step_max) : 31'sd0;
        dst = fsp_pkg::DST_SY;
        state_next = fsp_pkg::ST_TURN;
      end
      fsp_pkg::ST_TURN: begin
        mul_a = 32'(vt);
        mul_b = 31'(((right && vt > 16'sd0) || (!right && vt <= 16'sd0)) ?
                turn_out_max : turn_in_max);
        dst = fsp_pkg::DST_TURN;
        state_next = fsp_pkg::ST_ROT1;
      end
      fsp_pkg::ST_ROT1: begin
        cstart = 1'b1;
        state_next = fsp_pkg::ST_ROT1_WAIT;
      end
      fsp_pkg::ST_ROT1_WAIT: if (!cbusy) state_next = fsp_pkg::ST_G1X;
      fsp_pkg::ST_G1X: begin
        mul_a = cx;
        dst = fsp_pkg::DST_PX;
        state_next = fsp_pkg::ST_G1Y;
      end
      fsp_pkg::ST_G1Y: begin
        mul_a = cy;
        dst = fsp_pkg::DST_PY;
        state_next = fsp_pkg::ST_ROT2;
      end
      fsp_pkg::ST_ROT2: begin
        cstart = 1'b1;
        cx0 = 18'sd0;
        cy0 = 18'(hip);
        cang = head2;
        state_next = fsp_pkg::ST_ROT2_WAIT;
      end
      fsp_pkg::ST_ROT2_WAIT: if (!cbusy) state_next = fsp_pkg::ST_G2X;
      fsp_pkg::ST_G2X: begin
        mul_a = cx;
        dst = fsp_pkg::DST_QX;
        state_next = fsp_pkg::ST_G2Y;
      end
      fsp_pkg::ST_G2Y: begin
        mul_a = cy;
        dst = fsp_pkg::DST_QY;
        state_next = fsp_pkg::ST_FLUSH;
      end
      fsp_pkg::ST_FLUSH: state_next = fsp_pkg::ST_SUM;
      fsp_pkg::ST_SUM: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          state_next = fsp_pkg::ST_IDLE;
        end
      end
      default: state_next = fsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 63'(mul_a) * 63'(mul_b);
  end

  logic [62:0] pabs, r14, r42;
  logic [17:0] rmag;
  logic signed [17:0] rnd;

  always_comb begin
    pabs = prod[62] ? 63'(-prod) : 63'(prod);
    r14 = (pabs + 63'd8192) >> 14;
    r42 = (pabs + 63'h200_0000_0000) >> 42;
    rmag = (pdst == fsp_pkg::DST_SX || pdst == fsp_pkg::DST_SY ||
            pdst == fsp_pkg::DST_TURN) ? r14[17:0] : r42[17:0];
    rnd = prod[62] ? -$signed(rmag) : $signed(rmag);
  end

  always_ff @(posedge clk) begin
    case (pdst)
      fsp_pkg::DST_SX: sx <= rnd;
      fsp_pkg::DST_SY: sy <= rnd;
      fsp_pkg::DST_TURN: turn <= rnd;
      fsp_pkg::DST_PX: px <= rnd;
      fsp_pkg::DST_PY: py <= rnd;
      fsp_pkg::DST_QX: qx <= rnd;
      fsp_pkg::DST_QY: qy <= rnd;
      default: ;
    endcase
  end

  logic signed [23:0] sum_x, sum_y;
  logic signed [21:0] tx, ty;

  always_comb begin
    sum_x = 24'(fx) + 24'(px) + 24'(qx);
    sum_y = 24'(fy) + 24'(py) + 24'(qy);
    tx = sum_x > 24'sd2097151 ? 22'sd2097151 :
         (sum_x < -24'sd2097152 ? -22'sd2097152 : sum_x[21:0]);
    ty = sum_y > 24'sd2097151 ? 22'sd2097151 :
         (sum_y < -24'sd2097152 ? -22'sd2097152 : sum_y[21:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {step_index + 16'd1, phase_count, stand ? fsp_pkg::LEG_BOTH : leg,
                  leg, head2, ty, tx};
    end
  end

endmodule
`default_nettype wire
